@@ sv/bclru_pkg.sv @@
package bclru_pkg;

  localparam logic [1:0] FUNC_GET  = 2'd0;
  localparam logic [1:0] FUNC_DROP = 2'd1;
  localparam logic [1:0] FUNC_PIN  = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_FREE   = 2'd1;
  localparam logic [1:0] STAT_UNDERFLOW = 2'd2;
  localparam logic [1:0] STAT_OVERFLOW  = 2'd3;

  localparam logic [7:0]  COUNT_MAX = 8'hFF;
  localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_UPDATE
  } state_e;

  typedef enum logic [1:0] {
    OP_HIT,
    OP_ALLOC,
    OP_INC,
    OP_DEC
  } cell_op_e;

  typedef struct packed {
    logic        found;
    logic        have;
    logic [31:0] best;
  } srch_t;

  typedef struct packed {
    logic     wr_en;
    cell_op_e op;
  } cmd_t;

endpackage

@@ sv/bclru_if.sv @@
interface bclru_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [7:0]  dev;
  logic [31:0] block_number;
  logic [4:0]  buffer_select;
  logic [31:0] now;

  modport source (output valid, func, dev, block_number, buffer_select, now, input ready);
  modport sink (input valid, func, dev, block_number, buffer_select, now, output ready);
endinterface

interface bclru_rsp_if;
  logic       valid;
  logic       ready;
  logic [4:0] buffer_index;
  logic       hit;
  logic       needs_fill;
  logic [1:0] status;

  modport source (output valid, buffer_index, hit, needs_fill, status, input ready);
  modport sink (input valid, buffer_index, hit, needs_fill, status, output ready);
endinterface

@@ sv/bclru_cell.sv @@
module bclru_cell #(
  parameter int IDX_W      = 5,
  parameter int CELL_INDEX = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [7:0]         dev_i,
  input  logic [31:0]        blk_i,
  input  logic [31:0]        now_i,
  input  bclru_pkg::srch_t   srch_i,
  input  logic [IDX_W-1:0]   fidx_i,
  input  logic [IDX_W-1:0]   bidx_i,
  output bclru_pkg::srch_t   srch_o,
  output logic [IDX_W-1:0]   fidx_o,
  output logic [IDX_W-1:0]   bidx_o,
  input  bclru_pkg::cmd_t    cmd_i,
  input  logic [IDX_W-1:0]   cmd_idx_i,
  output logic [7:0]         ref_count_o,
  output logic               filled_o
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(CELL_INDEX);

  logic [7:0]  tag_dev_q;
  logic [31:0] tag_blk_q;
  logic [7:0]  ref_q, ref_d;
  logic [31:0] last_q, last_d;
  logic        filled_q, filled_d;
  logic        retag;

  bclru_pkg::srch_t srch_d, srch_q;
  logic [IDX_W-1:0] fidx_d, fidx_q, bidx_d, bidx_q;

  always_comb begin
    srch_d = srch_i;
    fidx_d = fidx_i;
    bidx_d = bidx_i;
    if (!srch_i.found && tag_dev_q == dev_i && tag_blk_q == blk_i) begin
      srch_d.found = 1'b1;
      fidx_d       = MY_IDX;
    end
    if (ref_q == 8'd0 && last_q < srch_i.best) begin
      srch_d.have = 1'b1;
      srch_d.best = last_q;
      bidx_d      = MY_IDX;
    end
  end

  always_ff @(posedge clk_i) begin
    srch_q <= srch_d;
    fidx_q <= fidx_d;
    bidx_q <= bidx_d;
  end

  always_comb begin
    ref_d    = ref_q;
    last_d   = last_q;
    filled_d = filled_q;
    retag    = 1'b0;
    if (cmd_i.wr_en && cmd_idx_i == MY_IDX) begin
      case (cmd_i.op)
        bclru_pkg::OP_HIT: begin
          ref_d    = ref_q + 8'd1;
          last_d   = now_i;
          filled_d = 1'b1;
        end
        bclru_pkg::OP_ALLOC: begin
          retag    = 1'b1;
          ref_d    = 8'd1;
          last_d   = now_i;
          filled_d = 1'b1;
        end
        bclru_pkg::OP_INC: ref_d = ref_q + 8'd1;
        bclru_pkg::OP_DEC: ref_d = ref_q - 8'd1;
        default: ref_d = ref_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_dev_q <= '0;
      tag_blk_q <= '0;
      ref_q     <= '0;
      last_q    <= '0;
      filled_q  <= 1'b0;
    end else begin
      ref_q    <= ref_d;
      last_q   <= last_d;
      filled_q <= filled_d;
      if (retag) begin
        tag_dev_q <= dev_i;
        tag_blk_q <= blk_i;
      end
    end
  end

  assign srch_o      = srch_q;
  assign fidx_o      = fidx_q;
  assign bidx_o      = bidx_q;
  assign ref_count_o = ref_q;
  assign filled_o    = filled_q;

endmodule

@@ sv/block_cache_lru_tag_store_top.sv @@
// Channel  Direction  Payload
// req_i    in         func, dev, block_number, buffer_select, now
// rsp_o    out        buffer_index, hit, needs_fill, status
//
// A get passes its lookup once down the chain of entry cells, one cell per
// cycle, then the update state applies the update.
// A drop or pin goes straight to the update state. One request is in work at a time.
// Reset clears every entry at once; no clearing pass is needed.
// A stalled response holds the block in its update cycle; a new request is
// accepted while the previous response still waits in the output register.
module block_cache_lru_tag_store_top #(
  parameter int NUM_BUFFERS = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  bclru_req_if.sink          req_i,
  bclru_rsp_if.source        rsp_o
);

  localparam int IDX_W = $clog2(NUM_BUFFERS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_BUFFERS - 1);

  bclru_pkg::state_e state_q, state_d;
  logic [IDX_W-1:0]  cnt_q, cnt_d;

  logic [1:0]  func_q;
  logic [7:0]  dev_q;
  logic [31:0] blk_q;
  logic [4:0]  sel_q;
  logic [31:0] now_q;

  logic       out_valid_q;
  logic [4:0] out_idx_q, out_idx_d;
  logic       out_hit_q, out_hit_d;
  logic       out_fill_q, out_fill_d;
  logic [1:0] out_stat_q, out_stat_d;
  logic       load_out;

  bclru_pkg::srch_t srch [NUM_BUFFERS];
  logic [IDX_W-1:0] fidx [NUM_BUFFERS];
  logic [IDX_W-1:0] bidx [NUM_BUFFERS];
  logic [7:0]       ref_cnt [NUM_BUFFERS];
  logic             filled [NUM_BUFFERS];

  bclru_pkg::srch_t srch_init;
  bclru_pkg::cmd_t  cmd, cmd_go;
  logic [IDX_W-1:0] cmd_idx;
  logic [IDX_W-1:0] sel_idx;
  logic             sel_ok;
  logic             accept;

  assign srch_init = '{found: 1'b0, have: 1'b0, best: bclru_pkg::STAMP_MAX};

  for (genvar g = 0; g < NUM_BUFFERS; g++) begin : g_cell
    bclru_cell #(
      .IDX_W      (IDX_W),
      .CELL_INDEX (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .dev_i       (dev_q),
      .blk_i       (blk_q),
      .now_i       (now_q),
      .srch_i      ((g == 0) ? srch_init : srch[(g == 0) ? 0 : g - 1]),
      .fidx_i      ((g == 0) ? '0 : fidx[(g == 0) ? 0 : g - 1]),
      .bidx_i      ((g == 0) ? '0 : bidx[(g == 0) ? 0 : g - 1]),
      .srch_o      (srch[g]),
      .fidx_o      (fidx[g]),
      .bidx_o      (bidx[g]),
      .cmd_i       (cmd_go),
      .cmd_idx_i   (cmd_idx),
      .ref_count_o (ref_cnt[g]),
      .filled_o    (filled[g])
    );
  end

  assign accept  = req_i.valid && req_i.ready;
  assign sel_idx = IDX_W'(sel_q);
  assign sel_ok  = 32'(sel_q) < 32'(NUM_BUFFERS);

  always_comb begin
    cmd        = '{wr_en: 1'b0, op: bclru_pkg::OP_HIT};
    cmd_idx    = sel_idx;
    out_idx_d  = sel_q;
    out_hit_d  = 1'b0;
    out_fill_d = 1'b0;
    out_stat_d = bclru_pkg::STAT_OK;
    case (func_q)
      bclru_pkg::FUNC_GET: begin
        if (srch[NUM_BUFFERS-1].found) begin
          cmd_idx   = fidx[NUM_BUFFERS-1];
          out_idx_d = 5'(fidx[NUM_BUFFERS-1]);
          out_hit_d = 1'b1;
          if (ref_cnt[cmd_idx] == bclru_pkg::COUNT_MAX) begin
            out_stat_d = bclru_pkg::STAT_OVERFLOW;
          end else begin
            cmd        = '{wr_en: 1'b1, op: bclru_pkg::OP_HIT};
            out_fill_d = !filled[cmd_idx];
          end
        end else if (srch[NUM_BUFFERS-1].have) begin
          cmd_idx    = bidx[NUM_BUFFERS-1];
          cmd        = '{wr_en: 1'b1, op: bclru_pkg::OP_ALLOC};
          out_idx_d  = 5'(bidx[NUM_BUFFERS-1]);
          out_fill_d = 1'b1;
        end else begin
          out_idx_d  = 5'd0;
          out_stat_d = bclru_pkg::STAT_NO_FREE;
        end
      end
      bclru_pkg::FUNC_DROP: begin
        if (sel_ok) begin
          if (ref_cnt[sel_idx] == 8'd0) begin
            out_stat_d = bclru_pkg::STAT_UNDERFLOW;
          end else begin
            cmd = '{wr_en: 1'b1, op: bclru_pkg::OP_DEC};
          end
        end
      end
      bclru_pkg::FUNC_PIN: begin
        if (sel_ok) begin
          if (ref_cnt[sel_idx] == bclru_pkg::COUNT_MAX) begin
            out_stat_d = bclru_pkg::STAT_OVERFLOW;
          end else begin
            cmd = '{wr_en: 1'b1, op: bclru_pkg::OP_INC};
          end
        end
      end
      default: out_stat_d = bclru_pkg::STAT_OK;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    load_out    = 1'b0;
    req_i.ready = 1'b0;
    cmd_go      = cmd;
    cmd_go.wr_en = 1'b0;
    case (state_q)
      bclru_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid) begin
          cnt_d   = '0;
          state_d = (req_i.func == bclru_pkg::FUNC_GET) ? bclru_pkg::ST_SEARCH
                                                        : bclru_pkg::ST_UPDATE;
        end
      end
      bclru_pkg::ST_SEARCH: begin
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_q == LAST_IDX) begin
          state_d = bclru_pkg::ST_UPDATE;
        end
      end
      bclru_pkg::ST_UPDATE: begin
        if (!out_valid_q || rsp_o.ready) begin
          load_out     = 1'b1;
          cmd_go.wr_en = cmd.wr_en;
          state_d      = bclru_pkg::ST_IDLE;
        end
      end
      default: state_d = bclru_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bclru_pkg::ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= req_i.func;
      dev_q  <= req_i.dev;
      blk_q  <= req_i.block_number;
      sel_q  <= req_i.buffer_select;
      now_q  <= req_i.now;
    end
    if (load_out) begin
      out_idx_q  <= out_idx_d;
      out_hit_q  <= out_hit_d;
      out_fill_q <= out_fill_d;
      out_stat_q <= out_stat_d;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.buffer_index = out_idx_q;
  assign rsp_o.hit          = out_hit_q;
  assign rsp_o.needs_fill   = out_fill_q;
  assign rsp_o.status       = out_stat_q;

  a_search_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bclru_pkg::ST_SEARCH |-> cnt_q <= LAST_IDX)
    else $error("Search counter ran past the last cell.");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != bclru_pkg::ST_IDLE)
    else $error("Accepted request did not start work.");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out |-> (!out_valid_q || rsp_o.ready))
    else $error("Pending response overwritten.");

  a_alloc_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_go.wr_en && cmd_go.op == bclru_pkg::OP_ALLOC |-> ref_cnt[cmd_idx] == 8'd0)
    else $error("Allocation chose a referenced entry.");

  a_write_in_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_go.wr_en |=> state_q == bclru_pkg::ST_IDLE && out_valid_q)
    else $error("Entry update without a delivered response.");

endmodule

@@ verif/block_cache_lru_tag_store_top_tb.sv @@
module block_cache_lru_tag_store_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          NB          = 32;
  localparam int          HALF_PERIOD = 10;
  localparam int          HOLD_CYCLES = 400;
  localparam int          POOL_SIZE   = 24;
  localparam int          PHASE_ITEMS = 70;
  localparam longint      TIMEOUT_NS  = 64'd20_000_000;
  localparam logic [1:0]  FUNC_SPARE  = 2'd3;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [4:0]  sel;
    logic [31:0] now;
  } cache_req_t;

  typedef struct packed {
    logic [4:0] idx;
    logic       hit;
    logic       fill;
    logic [1:0] status;
  } cache_reply_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic rx_hold = 1'b0;
  int   send_idle_pct = 0;
  int   stall_pct = 0;
  int   mismatches = 0;
  event hold_go;

  logic [7:0]  tag_dev_m  [NB];
  logic [31:0] tag_blk_m  [NB];
  logic [7:0]  refs_m     [NB];
  logic [31:0] stamp_m    [NB];
  logic        filled_m   [NB];
  logic [31:0] tick;
  logic [7:0]  pool_dev   [POOL_SIZE];
  logic [31:0] pool_blk   [POOL_SIZE];

  cache_reply_t replies_due[$];

  bclru_req_if req_if();
  bclru_rsp_if rsp_if();

  block_cache_lru_tag_store_top #(.NUM_BUFFERS(NB)) dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  always #(HALF_PERIOD) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rsp_if.ready <= !rx_hold && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    forever begin
      @(hold_go);
      rx_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk_i);
      rx_hold <= 1'b0;
    end
  end

  function automatic cache_reply_t tag_store_apply(cache_req_t r);
    cache_reply_t o;
    int           idx;
    bit           found;
    bit           have;
    logic [31:0]  best;
    o = '{idx: r.sel, hit: 1'b0, fill: 1'b0, status: bclru_pkg::STAT_OK};
    case (r.func)
      bclru_pkg::FUNC_GET: begin
        found = 1'b0;
        idx = 0;
        for (int i = 0; i < NB; i++) begin
          if (!found && tag_dev_m[i] == r.dev && tag_blk_m[i] == r.blk) begin
            found = 1'b1;
            idx = i;
          end
        end
        if (found) begin
          o.idx = 5'(idx);
          o.hit = 1'b1;
          if (refs_m[idx] == bclru_pkg::COUNT_MAX) begin
            o.status = bclru_pkg::STAT_OVERFLOW;
          end else begin
            refs_m[idx] = refs_m[idx] + 8'd1;
            stamp_m[idx] = r.now;
            o.fill = !filled_m[idx];
            filled_m[idx] = 1'b1;
          end
        end else begin
          best = bclru_pkg::STAMP_MAX;
          have = 1'b0;
          for (int i = 0; i < NB; i++) begin
            if (refs_m[i] == 8'd0 && stamp_m[i] < best) begin
              best = stamp_m[i];
              idx = i;
              have = 1'b1;
            end
          end
          if (!have) begin
            o.idx = 5'd0;
            o.status = bclru_pkg::STAT_NO_FREE;
          end else begin
            tag_dev_m[idx] = r.dev;
            tag_blk_m[idx] = r.blk;
            refs_m[idx] = 8'd1;
            stamp_m[idx] = r.now;
            filled_m[idx] = 1'b1;
            o.idx = 5'(idx);
            o.fill = 1'b1;
          end
        end
      end
      bclru_pkg::FUNC_DROP: begin
        if (int'(r.sel) < NB) begin
          if (refs_m[r.sel] == 8'd0) o.status = bclru_pkg::STAT_UNDERFLOW;
          else refs_m[r.sel] = refs_m[r.sel] - 8'd1;
        end
      end
      bclru_pkg::FUNC_PIN: begin
        if (int'(r.sel) < NB) begin
          if (refs_m[r.sel] == bclru_pkg::COUNT_MAX) o.status = bclru_pkg::STAT_OVERFLOW;
          else refs_m[r.sel] = refs_m[r.sel] + 8'd1;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  function automatic logic [31:0] advance_clock();
    int pick;
    pick = $urandom_range(99);
    tick = tick + 32'($urandom_range(1, 50));
    if (pick < 4) return $urandom;
    if (pick < 6) return bclru_pkg::STAMP_MAX;
    if (pick < 8) return 32'd0;
    return tick;
  endfunction

  task automatic send_req(input logic [1:0] func, input logic [7:0] dev,
                          input logic [31:0] blk, input logic [4:0] sel,
                          input logic [31:0] now);
    cache_req_t r;
    r = '{func: func, dev: dev, blk: blk, sel: sel, now: now};
    req_if.valid         <= 1'b1;
    req_if.func          <= func;
    req_if.dev           <= dev;
    req_if.block_number  <= blk;
    req_if.buffer_select <= sel;
    req_if.now           <= now;
    do @(posedge clk_i); while (!req_if.ready);
    replies_due.push_back(tag_store_apply(r));
    while ($urandom_range(99) < send_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk_i) begin
    cache_reply_t want;
    if (rst_ni === 1'b1 && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        $error("response: expected none, got index %0d", rsp_if.buffer_index);
        mismatches++;
      end else begin
        want = replies_due.pop_front();
        check_field("buffer_index", 32'(want.idx), 32'(rsp_if.buffer_index));
        check_field("hit", 32'(want.hit), 32'(rsp_if.hit));
        check_field("needs_fill", 32'(want.fill), 32'(rsp_if.needs_fill));
        check_field("status", 32'(want.status), 32'(rsp_if.status));
      end
    end
  end

  // Every tag starts as device 0, block 0, so the first gets hit entry 0.
  task automatic test_reset_tags();
    send_req(bclru_pkg::FUNC_GET, 8'h00, 32'h0, 5'd0, 32'd5);
    send_req(bclru_pkg::FUNC_GET, 8'h00, 32'h0, 5'd31, 32'd6);
    send_req(bclru_pkg::FUNC_DROP, 8'($urandom), $urandom, 5'd0, $urandom);
    send_req(bclru_pkg::FUNC_DROP, 8'($urandom), $urandom, 5'd0, $urandom);
    send_req(bclru_pkg::FUNC_DROP, 8'($urandom), $urandom, 5'd0, $urandom);
    send_req(bclru_pkg::FUNC_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, bclru_pkg::STAMP_MAX);
    send_req(bclru_pkg::FUNC_DROP, 8'hFF, 32'hFFFF_FFFF, 5'd1, 32'd0);
    send_req(bclru_pkg::FUNC_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'd7);
    send_req(bclru_pkg::FUNC_DROP, 8'h00, 32'h0, 5'd1, 32'd0);
    send_req(bclru_pkg::FUNC_PIN, 8'h5A, 32'h1234_5678, 5'd31, 32'd8);
    send_req(bclru_pkg::FUNC_DROP, 8'hA5, 32'h8765_4321, 5'd31, 32'd9);
    send_req(FUNC_SPARE, 8'hFF, 32'hFFFF_FFFF, 5'd17, bclru_pkg::STAMP_MAX);
    send_req(FUNC_SPARE, 8'h00, 32'h0, 5'd31, 32'd0);
  endtask

  // Once every entry holds a reference, a get finds no free entry.
  task automatic test_no_free();
    for (int k = 0; k < NB + 1; k++) begin
      send_req(bclru_pkg::FUNC_GET, 8'(k + 1), $urandom, 5'($urandom), 32'(100 + k));
    end
    send_req(bclru_pkg::FUNC_DROP, 8'h00, 32'h0, 5'd3, 32'd0);
    send_req(bclru_pkg::FUNC_DROP, 8'h00, 32'h0, 5'd30, 32'd0);
    send_req(bclru_pkg::FUNC_DROP, 8'h00, 32'h0, 5'd1, 32'd0);
    send_req(bclru_pkg::FUNC_GET, 8'hC3, $urandom, 5'd0, 32'd200);
    send_req(bclru_pkg::FUNC_GET, 8'hC4, $urandom, 5'd0, 32'd201);
    send_req(bclru_pkg::FUNC_GET, 8'hC5, $urandom, 5'd0, 32'd202);
  endtask

  task automatic test_count_limits();
    while (refs_m[9] != bclru_pkg::COUNT_MAX) begin
      send_req(bclru_pkg::FUNC_PIN, 8'($urandom), $urandom, 5'd9, $urandom);
    end
    send_req(bclru_pkg::FUNC_PIN, 8'($urandom), $urandom, 5'd9, $urandom);
    send_req(bclru_pkg::FUNC_GET, tag_dev_m[9], tag_blk_m[9], 5'd0, 32'd300);
    send_req(bclru_pkg::FUNC_DROP, 8'($urandom), $urandom, 5'd9, $urandom);
    send_req(bclru_pkg::FUNC_GET, tag_dev_m[9], tag_blk_m[9], 5'd0, 32'd301);
  endtask

  task automatic random_item();
    int          pick;
    int          busy[$];
    logic [31:0] now;
    logic [7:0]  dev;
    logic [31:0] blk;
    int          slot;
    pick = $urandom_range(99);
    now = advance_clock();
    if (pick < 40) begin
      if ($urandom_range(99) < 65) begin
        slot = $urandom_range(POOL_SIZE - 1);
        dev = pool_dev[slot];
        blk = pool_blk[slot];
      end else begin
        dev = 8'($urandom);
        blk = $urandom;
      end
      send_req(bclru_pkg::FUNC_GET, dev, blk, 5'($urandom), now);
    end else if (pick < 85) begin
      for (int i = 0; i < NB; i++) if (refs_m[i] != 8'd0) busy.push_back(i);
      if (busy.size() != 0 && $urandom_range(99) < 85) begin
        slot = busy[$urandom_range(busy.size() - 1)];
      end else begin
        slot = $urandom_range(NB - 1);
      end
      send_req(bclru_pkg::FUNC_DROP, 8'($urandom), $urandom, 5'(slot), now);
    end else if (pick < 93) begin
      send_req(bclru_pkg::FUNC_PIN, 8'($urandom), $urandom, 5'($urandom), now);
    end else begin
      send_req(FUNC_SPARE, 8'($urandom), $urandom, 5'($urandom), now);
    end
  endtask

  // The sender keeps offering requests while responses are held back.
  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    -> hold_go;
    repeat (10) random_item();
  endtask

  task automatic test_random();
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_dev[i] = 8'($urandom);
      pool_blk[i] = $urandom;
    end
    pool_dev[0] = 8'h00;
    pool_blk[0] = 32'h0;
    pool_dev[1] = 8'hFF;
    pool_blk[1] = 32'hFFFF_FFFF;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 78; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 78; end
        default: begin send_idle_pct = 7; stall_pct = 7; end
      endcase
      repeat (PHASE_ITEMS) random_item();
    end
  endtask

  initial begin
    #(TIMEOUT_NS);
    $display("tb: failure");
    $finish;
  end

  initial begin
    rst_ni               <= 1'b0;
    req_if.valid         <= 1'b0;
    req_if.func          <= bclru_pkg::FUNC_GET;
    req_if.dev           <= 8'h00;
    req_if.block_number  <= 32'h0;
    req_if.buffer_select <= 5'd0;
    req_if.now           <= 32'h0;
    tick = 32'd1000;
    for (int i = 0; i < NB; i++) begin
      tag_dev_m[i] = 8'h00;
      tag_blk_m[i] = 32'h0;
      refs_m[i] = 8'd0;
      stamp_m[i] = 32'h0;
      filled_m[i] = 1'b0;
    end
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_tags();
    test_no_free();
    test_count_limits();
    test_backpressure();
    test_random();
    req_if.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk_i);
    repeat (NB + 4) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
sv/bclru_pkg.sv
sv/bclru_if.sv
sv/bclru_cell.sv
sv/block_cache_lru_tag_store_top.sv
verif/block_cache_lru_tag_store_top_tb.sv
